// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands; the including module supplies i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define HPRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define HPRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked across reset.
`define HPRA_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hpra_pkg.sv =====
package hpra_pkg;

    localparam int DIR_ENTRIES     = 512;
    localparam int PAGES_PER_ENTRY = 512;
    localparam int TOTAL_PAGES     = DIR_ENTRIES * PAGES_PER_ENTRY;

    // fixed item field widths
    localparam int OP_W       = 2;
    localparam int PAGE_NUM_W = 18;
    localparam int PAGE_CNT_W = 19;

    localparam int ENT_W = $clog2(DIR_ENTRIES);
    localparam int OFF_W = $clog2(PAGES_PER_ENTRY);
    localparam int PG_W  = $clog2(TOTAL_PAGES);
    localparam int CNT_W = $clog2(TOTAL_PAGES + 1);
    localparam int CMP_W = (CNT_W > PAGE_CNT_W) ? CNT_W : PAGE_CNT_W;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_SMALL = 2'd0,
        OP_ALLOC_HUGE  = 2'd1,
        OP_FREE_SMALL  = 2'd2,
        OP_FREE_HUGE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_TABLE = 2'd1,
        KIND_HUGE  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SA_DRD,
        S_SA_DCHK,
        S_SA_PRD,
        S_SA_PCHK,
        S_SB_RD,
        S_SB_CHK,
        S_HA_RD,
        S_HA_CHK,
        S_MARK,
        S_HWR,
        S_FS,
        S_FH,
        S_DONE
    } t_state;

endpackage

// ===== rtl/core/hpra_req_if.sv =====
interface hpra_req_if;
    logic                             valid;
    logic                             ready;
    logic [hpra_pkg::OP_W-1:0]        operation;
    logic [hpra_pkg::PAGE_NUM_W-1:0]  page_number;
    logic [hpra_pkg::PAGE_CNT_W-1:0]  page_count;

    modport source (output valid, operation, page_number, page_count, input ready);
    modport sink   (input valid, operation, page_number, page_count, output ready);
endinterface

// ===== rtl/core/hpra_rsp_if.sv =====
interface hpra_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [hpra_pkg::PAGE_NUM_W-1:0]  start_page;
    logic                             status;

    modport source (output valid, start_page, status, input ready);
    modport sink   (input valid, start_page, status, output ready);
endinterface

// ===== rtl/core/hpra_ram.sv =====
module hpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

// ===== rtl/core/heap_page_run_allocator.sv =====
// First-fit page-run allocator over a two-level page heap.
// Request channel i_req: operation (alloc small, alloc huge, free small,
// free huge), page_number (first page of a free), page_count.
// Response channel o_rsp: one item per request, start_page and status
// (1 = out of memory, start_page then 0).
// State lives in two single-port-write RAMs with registered read: a 2-bit
// directory (512 entries) and a 1-bit page map (262144 pages).
// One request at a time. Each directory entry inspected takes a read
// state, then a check state; each page of a table scanned likewise
// takes a read, then a check; each page or entry marked or freed is
// written from the mark or free state; dispatch and response come on
// top. A small allocation that scans every table runs longest, so the
// page-map read loop sets the worst case; a zero count goes straight
// from dispatch to the response.
// Reset: a clearing pass over every page writes both RAMs to zero (free,
// unused); i_req.ready stays low until it ends.
// Stall: a finished response waits in the output register; the next
// request is still accepted and processed, and its result holds until the
// output register is taken.
module heap_page_run_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hpra_req_if.sink     i_req,
    hpra_rsp_if.source   o_rsp
);
    import hpra_pkg::*;

    localparam logic [CNT_W-1:0] PPE_C   = CNT_W'(PAGES_PER_ENTRY);
    localparam logic [ENT_W-1:0] LAST_E  = ENT_W'(DIR_ENTRIES - 1);
    localparam logic [OFF_W-1:0] LAST_O  = OFF_W'(PAGES_PER_ENTRY - 1);
    localparam logic [PG_W-1:0]  LAST_P  = PG_W'(TOTAL_PAGES - 1);
    localparam logic [PG_W-1:0]  DIR_P   = PG_W'(DIR_ENTRIES);

    t_state                r_state, n_state;
    logic [PG_W-1:0]       r_clr, n_clr;
    logic [CMP_W-1:0]      r_amt, n_amt;
    logic [CMP_W-1:0]      r_cnt, n_cnt;
    logic [CMP_W-1:0]      r_left, n_left;
    logic [ENT_W-1:0]      r_ent, n_ent;
    logic [ENT_W-1:0]      r_run_ent, n_run_ent;
    logic [OFF_W-1:0]      r_off, n_off;
    logic [CNT_W-1:0]      r_pg, n_pg;      // page of r_ent/r_off
    logic [CNT_W-1:0]      r_run, n_run;    // run start, pages
    logic [CNT_W-1:0]      r_mpg, n_mpg;    // mark/free cursor
    logic                  r_mtab, n_mtab;
    logic [PAGE_NUM_W-1:0] r_start, n_start;
    logic                  r_status, n_status;
    logic                  r_ovalid, n_ovalid;
    logic [PAGE_NUM_W-1:0] r_ostart, n_ostart;
    logic                  r_ostatus, n_ostatus;

    // RAM ports
    logic                  dir_we;
    logic [ENT_W-1:0]      dir_waddr;
    logic [1:0]            dir_wdata;
    logic [1:0]            dir_rdata;
    logic                  pg_we;
    logic [PG_W-1:0]       pg_waddr;
    logic                  pg_wdata;
    logic                  pg_rdata;

    logic [CMP_W-1:0]      cnt_inc;
    logic [CMP_W-1:0]      cnt_ppe;
    t_kind                 kind;

    hpra_ram #(.WIDTH(2), .DEPTH(DIR_ENTRIES)) u_dir (
        .i_clk   (i_clk),
        .i_we    (dir_we),
        .i_waddr (dir_waddr),
        .i_wdata (dir_wdata),
        .i_raddr (r_ent),
        .o_rdata (dir_rdata)
    );

    hpra_ram #(.WIDTH(1), .DEPTH(TOTAL_PAGES)) u_pages (
        .i_clk   (i_clk),
        .i_we    (pg_we),
        .i_waddr (pg_waddr),
        .i_wdata (pg_wdata),
        .i_raddr (r_pg[PG_W-1:0]),
        .o_rdata (pg_rdata)
    );

    assign kind    = t_kind'(dir_rdata);
    assign cnt_inc = r_cnt + CMP_W'(1);
    assign cnt_ppe = r_cnt + CMP_W'(PAGES_PER_ENTRY);

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.start_page = r_ostart;
    assign o_rsp.status    = r_ostatus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amt     <= n_amt;
        r_cnt     <= n_cnt;
        r_left    <= n_left;
        r_ent     <= n_ent;
        r_run_ent <= n_run_ent;
        r_off     <= n_off;
        r_pg      <= n_pg;
        r_run     <= n_run;
        r_mpg     <= n_mpg;
        r_mtab    <= n_mtab;
        r_start   <= n_start;
        r_status  <= n_status;
        r_ostart  <= n_ostart;
        r_ostatus <= n_ostatus;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_amt     = r_amt;
        n_cnt     = r_cnt;
        n_left    = r_left;
        n_ent     = r_ent;
        n_run_ent = r_run_ent;
        n_off     = r_off;
        n_pg      = r_pg;
        n_run     = r_run;
        n_mpg     = r_mpg;
        n_mtab    = r_mtab;
        n_start   = r_start;
        n_status  = r_status;
        n_ostart  = r_ostart;
        n_ostatus = r_ostatus;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        dir_we    = 1'b0;
        dir_waddr = r_ent;
        dir_wdata = KIND_FREE;
        pg_we     = 1'b0;
        pg_waddr  = r_mpg[PG_W-1:0];
        pg_wdata  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                pg_we     = 1'b1;
                pg_waddr  = r_clr;
                dir_we    = (r_clr < DIR_P);
                dir_waddr = r_clr[ENT_W-1:0];
                n_clr     = r_clr + PG_W'(1);
                if (r_clr == LAST_P) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (i_req.valid) begin
                    n_amt     = CMP_W'(i_req.page_count);
                    n_left    = CMP_W'(i_req.page_count);
                    n_ent     = '0;
                    n_run_ent = '0;
                    n_off     = '0;
                    n_pg      = '0;
                    n_run     = '0;
                    n_cnt     = '0;
                    n_start   = '0;
                    n_status  = 1'b0;
                    n_mpg     = CNT_W'(i_req.page_number);
                    if (i_req.page_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        unique case (t_op'(i_req.operation))
                            OP_ALLOC_SMALL: n_state = S_SA_DRD;
                            OP_ALLOC_HUGE:  n_state = S_HA_RD;
                            OP_FREE_SMALL:  n_state = S_FS;
                            OP_FREE_HUGE: begin
                                n_ent   = ENT_W'(i_req.page_number / PAGES_PER_ENTRY);
                                n_state = S_FH;
                            end
                        endcase
                    end
                end
            end

            // search existing tables for a free page run
            S_SA_DRD: n_state = S_SA_DCHK;

            S_SA_DCHK: begin
                if (kind == KIND_TABLE) begin
                    n_off   = '0;
                    n_state = S_SA_PRD;
                end else begin
                    n_pg  = r_pg + PPE_C;
                    n_run = r_pg + PPE_C;
                    n_cnt = '0;
                    if (r_ent == LAST_E) begin
                        n_ent = '0; n_pg = '0; n_run = '0; n_run_ent = '0;
                        n_state = S_SB_RD;
                    end else begin
                        n_ent   = r_ent + ENT_W'(1);
                        n_state = S_SA_DRD;
                    end
                end
            end

            S_SA_PRD: n_state = S_SA_PCHK;

            S_SA_PCHK: begin
                if (!pg_rdata && (cnt_inc >= r_amt)) begin
                    n_mpg   = r_run;
                    n_left  = cnt_inc;
                    n_mtab  = 1'b0;
                    n_start = r_run[PAGE_NUM_W-1:0];
                    n_state = S_MARK;
                end else begin
                    if (pg_rdata) begin
                        n_run = r_pg + CNT_W'(1);
                        n_cnt = '0;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                    n_pg = r_pg + CNT_W'(1);
                    if (r_off == LAST_O) begin
                        if (r_ent == LAST_E) begin
                            n_ent = '0; n_pg = '0; n_run = '0; n_run_ent = '0;
                            n_cnt = '0;
                            n_state = S_SB_RD;
                        end else begin
                            n_ent   = r_ent + ENT_W'(1);
                            n_state = S_SA_DRD;
                        end
                    end else begin
                        n_off   = r_off + OFF_W'(1);
                        n_state = S_SA_PRD;
                    end
                end
            end

            // take free directory entries and turn them into tables
            S_SB_RD: n_state = S_SB_CHK;

            S_SB_CHK: begin
                if (kind == KIND_FREE && cnt_ppe >= r_amt) begin
                    n_mpg   = r_run;
                    n_ent   = r_run_ent;
                    n_off   = '0;
                    n_left  = r_amt;
                    n_mtab  = 1'b1;
                    n_start = r_run[PAGE_NUM_W-1:0];
                    n_state = S_MARK;
                end else begin
                    if (kind == KIND_FREE) begin
                        n_cnt = cnt_ppe;
                    end else begin
                        n_cnt     = '0;
                        n_run_ent = r_ent + ENT_W'(1);
                        n_run     = r_pg + PPE_C;
                    end
                    n_pg = r_pg + PPE_C;
                    if (r_ent == LAST_E) begin
                        n_start  = '0;
                        n_status = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_ent   = r_ent + ENT_W'(1);
                        n_state = S_SB_RD;
                    end
                end
            end

            // huge run of free entries
            S_HA_RD: n_state = S_HA_CHK;

            S_HA_CHK: begin
                if (kind == KIND_FREE && cnt_inc >= r_amt) begin
                    n_ent   = r_run_ent;
                    n_left  = cnt_inc;
                    n_start = r_run[PAGE_NUM_W-1:0];
                    n_state = S_HWR;
                end else begin
                    if (kind == KIND_FREE) begin
                        n_cnt = cnt_inc;
                    end else begin
                        n_cnt     = '0;
                        n_run_ent = r_ent + ENT_W'(1);
                        n_run     = r_pg + PPE_C;
                    end
                    n_pg = r_pg + PPE_C;
                    if (r_ent == LAST_E) begin
                        n_start  = '0;
                        n_status = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_ent   = r_ent + ENT_W'(1);
                        n_state = S_HA_RD;
                    end
                end
            end

            S_MARK: begin
                pg_we     = 1'b1;
                pg_wdata  = 1'b1;
                dir_we    = r_mtab;
                dir_wdata = KIND_TABLE;
                n_mpg     = r_mpg + CNT_W'(1);
                n_left    = r_left - CMP_W'(1);
                if (r_off == LAST_O) begin
                    n_off = '0;
                    n_ent = r_ent + ENT_W'(1);
                end else begin
                    n_off = r_off + OFF_W'(1);
                end
                if (r_left == CMP_W'(1)) begin
                    n_state = S_DONE;
                end
            end

            S_HWR: begin
                dir_we    = 1'b1;
                dir_wdata = KIND_HUGE;
                n_ent     = r_ent + ENT_W'(1);
                n_left    = r_left - CMP_W'(1);
                if (r_left == CMP_W'(1)) begin
                    n_state = S_DONE;
                end
            end

            S_FS: begin
                pg_we  = 1'b1;
                n_mpg  = r_mpg + CNT_W'(1);
                n_left = r_left - CMP_W'(1);
                if (r_left == CMP_W'(1) || r_mpg[PG_W-1:0] == LAST_P) begin
                    n_state = S_DONE;
                end
            end

            S_FH: begin
                dir_we = 1'b1;
                n_ent  = r_ent + ENT_W'(1);
                n_left = r_left - CMP_W'(1);
                if (r_left == CMP_W'(1) || r_ent == LAST_E) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // hand over once the output register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostart  = r_start;
                    n_ostatus = r_status;
                    n_state   = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/hpra_checker.sv =====
module hpra_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_req_ready,
    input logic                             i_rsp_valid,
    input logic                             i_rsp_ready,
    input logic [hpra_pkg::PAGE_NUM_W-1:0]  i_rsp_start,
    input logic                             i_rsp_status
);
`include "assert_macros.svh"

    `HPRA_ASSERT_NXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid, "response dropped")
    `HPRA_ASSERT_NXT(a_rsp_stable, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_start) && $stable(i_rsp_status), "stalled response changed")
    `HPRA_ASSERT_IMP(a_oom_zero, i_rsp_valid && i_rsp_status, i_rsp_start == '0, "failed allocation with nonzero start")
    `HPRA_ASSERT_RST(a_clear_busy, !i_rst_n, !i_req_ready, "request taken during clearing pass")

endmodule

bind heap_page_run_allocator hpra_checker u_hpra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_start  (o_rsp.start_page),
    .i_rsp_status (o_rsp.status)
);

// ===== bench/heap_page_run_allocator_tb.sv =====
module heap_page_run_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hpra_pkg::*;

    // Idle cycles with no item moving on either side before the run is
    // declared hung. The clearing pass after reset and the worst single
    // request (full table scan plus marking) fit several times over.
    localparam int unsigned HANG_LIMIT = 4_000_000;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned ITEMS_PER_PHASE = 29;
    localparam int unsigned HOLDOFF_CYCLES = 20_000;
    localparam int unsigned NUM_ROWS = 24;

    typedef struct packed {
        logic [PAGE_NUM_W-1:0] start_page;
        logic                  status;
    } alloc_result_t;

    typedef struct packed {
        t_op                   op;
        logic [PAGE_NUM_W-1:0] page;
        logic [PAGE_CNT_W-1:0] count;
        logic                  fixed;      // expected result typed in below
        logic [PAGE_NUM_W-1:0] start_page;
        logic                  status;
    } stim_row_t;

    typedef struct packed {
        logic [PAGE_NUM_W-1:0] start_page;
        logic [PAGE_CNT_W-1:0] count;
    } run_t;

    logic clk;
    logic rst_n;

    hpra_req_if req_if ();
    hpra_rsp_if rsp_if ();

    heap_page_run_allocator dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the heap: directory kinds and page marks.
    // ------------------------------------------------------------------
    t_kind dir_kind [DIR_ENTRIES];
    bit    page_used [TOTAL_PAGES];

    alloc_result_t pending_results [$];
    run_t          small_runs [$];     // live small runs, candidates for frees
    run_t          huge_runs [$];

    int unsigned fail_count = 0;
    int unsigned items_in = 0;
    int unsigned items_out = 0;
    int unsigned oom_seen = 0;

    // Set alongside the request fields; tells the checker to use the typed value.
    logic                  row_fixed;
    logic [PAGE_NUM_W-1:0] row_start;
    logic                  row_status;

    // Sender / receiver knobs.
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          holdoff_go = 0;
    int unsigned holdoff_left = 0;

    function automatic void mark_run(longint first, longint cnt, bit make_tables);
        longint p;
        for (longint k = 0; k < cnt; k++) begin
            p = first + k;
            if (p >= TOTAL_PAGES) break;
            if (make_tables) dir_kind[p / PAGES_PER_ENTRY] = KIND_TABLE;
            page_used[p] = 1'b1;
        end
    endfunction

    // First fit over existing tables, then over free directory entries.
    function automatic bit place_small(longint amt, output longint first);
        longint run_at;
        longint len;
        longint p;
        run_at = 0;
        len = 0;
        first = 0;
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            if (dir_kind[i] == KIND_TABLE) begin
                for (int j = 0; j < PAGES_PER_ENTRY; j++) begin
                    p = longint'(i) * PAGES_PER_ENTRY + j;
                    if (page_used[p]) begin
                        run_at = p + 1;
                        len = 0;
                    end else begin
                        len++;
                        if (len >= amt) begin
                            mark_run(run_at, len, 1'b0);
                            first = run_at;
                            return 1'b1;
                        end
                    end
                end
            end else begin
                run_at = longint'(i + 1) * PAGES_PER_ENTRY;
                len = 0;
            end
        end
        run_at = 0;
        len = 0;
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            if (dir_kind[i] == KIND_FREE) begin
                len += PAGES_PER_ENTRY;
                if (len >= amt) begin
                    first = run_at * PAGES_PER_ENTRY;
                    mark_run(first, amt, 1'b1);
                    return 1'b1;
                end
            end else begin
                run_at = i + 1;
                len = 0;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit place_huge(longint amt, output longint first);
        longint run_at;
        longint len;
        run_at = 0;
        len = 0;
        first = 0;
        for (int i = 0; i < DIR_ENTRIES; i++) begin
            if (dir_kind[i] != KIND_FREE) begin
                run_at = i + 1;
                len = 0;
            end else begin
                len++;
                if (len >= amt) begin
                    for (longint k = 0; k < len; k++) dir_kind[run_at + k] = KIND_HUGE;
                    first = run_at * PAGES_PER_ENTRY;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the shadow heap and returns its response.
    function automatic alloc_result_t heap_apply(t_op op, longint page, longint cnt);
        alloc_result_t r;
        longint first;
        longint e;
        bit ok;
        r = '0;
        first = 0;
        if (cnt != 0) begin
            case (op)
                OP_ALLOC_SMALL: begin
                    ok = place_small(cnt, first);
                    if (ok) begin
                        r.start_page = first[PAGE_NUM_W-1:0];
                        small_runs.push_back({first[PAGE_NUM_W-1:0], cnt[PAGE_CNT_W-1:0]});
                    end else begin
                        r.status = 1'b1;
                    end
                end
                OP_ALLOC_HUGE: begin
                    ok = place_huge(cnt, first);
                    if (ok) begin
                        r.start_page = first[PAGE_NUM_W-1:0];
                        huge_runs.push_back({first[PAGE_NUM_W-1:0], cnt[PAGE_CNT_W-1:0]});
                    end else begin
                        r.status = 1'b1;
                    end
                end
                OP_FREE_SMALL: begin
                    for (longint k = 0; k < cnt && page + k < TOTAL_PAGES; k++)
                        page_used[page + k] = 1'b0;
                end
                default: begin
                    e = page / PAGES_PER_ENTRY;
                    for (longint k = 0; k < cnt && e + k < DIR_ENTRIES; k++)
                        dir_kind[e + k] = KIND_FREE;
                end
            endcase
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predicts on every accepted request, checks every response.
    // Sampled at the edge, before this edge's nonblocking updates land.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        alloc_result_t predicted;
        alloc_result_t want;
        if (rst_n && req_if.valid && req_if.ready) begin
            predicted = heap_apply(t_op'(req_if.operation), longint'(req_if.page_number),
                                   longint'(req_if.page_count));
            want = predicted;
            if (row_fixed) begin
                want.start_page = row_start;
                want.status = row_status;
            end
            pending_results.push_back(want);
            items_in++;
        end
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            items_out++;
            if (pending_results.size() == 0) begin
                $display("%0t: response with nothing outstanding: start_page %0d status %0d",
                         $time, rsp_if.start_page, rsp_if.status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_if.status === 1'b1) oom_seen++;
                if (rsp_if.start_page !== want.start_page) begin
                    $display("%0t: start_page mismatch: expected %0d actual %0d",
                             $time, want.start_page, rsp_if.start_page);
                    fail_count++;
                end
                if (rsp_if.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, rsp_if.status);
                    fail_count++;
                end
            end
        end
    end

    // Hang watchdog: counts cycles where no item moves.
    int unsigned quiet_cycles = 0;
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (holdoff_go) begin
            holdoff_go = 0;
            holdoff_left = HOLDOFF_CYCLES;
            rsp_if.ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------
    task automatic send_item(t_op op, logic [PAGE_NUM_W-1:0] page,
                             logic [PAGE_CNT_W-1:0] cnt, logic fixed,
                             logic [PAGE_NUM_W-1:0] want_start, logic want_status);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.operation <= op;
        req_if.page_number <= page;
        req_if.page_count <= cnt;
        row_fixed <= fixed;
        row_start <= want_start;
        row_status <= want_status;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic go_quiet();
        req_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending_results.size() == 0);
        @(posedge clk);
    endtask

    // Random request, weighted toward alloc/free pairs so that tables fill,
    // fragment and get reused; the rest is noise.
    task automatic send_random();
        int unsigned pick;
        int unsigned idx;
        run_t r;
        logic [PAGE_NUM_W-1:0] page;
        logic [PAGE_CNT_W-1:0] cnt;
        t_op op;
        pick = $urandom_range(99);
        page = '0;
        if (pick < 35) begin
            op = OP_ALLOC_SMALL;
            cnt = PAGE_CNT_W'(($urandom_range(19) == 0) ? $urandom_range(1200, 1)
                                                         : $urandom_range(48, 1));
        end else if (pick < 47) begin
            op = OP_ALLOC_HUGE;
            cnt = PAGE_CNT_W'($urandom_range(3, 1));
        end else if (pick < 72) begin
            op = OP_FREE_SMALL;
            if (small_runs.size() > 0) begin
                idx = $urandom_range(small_runs.size() - 1);
                r = small_runs[idx];
                small_runs.delete(idx);
                page = r.start_page;
                cnt = r.count;
            end else begin
                page = PAGE_NUM_W'($urandom_range(TOTAL_PAGES - 1));
                cnt = PAGE_CNT_W'($urandom_range(16, 1));
            end
        end else if (pick < 82) begin
            op = OP_FREE_HUGE;
            if (huge_runs.size() > 0) begin
                idx = $urandom_range(huge_runs.size() - 1);
                r = huge_runs[idx];
                huge_runs.delete(idx);
                page = r.start_page + PAGE_NUM_W'($urandom_range(PAGES_PER_ENTRY - 1));
                cnt = r.count;
            end else begin
                page = PAGE_NUM_W'($urandom_range(TOTAL_PAGES - 1));
                cnt = PAGE_CNT_W'($urandom_range(2, 1));
            end
        end else if (pick < 90) begin
            // stray small free anywhere, may hit huge entries or unused pages
            op = OP_FREE_SMALL;
            page = PAGE_NUM_W'($urandom_range(TOTAL_PAGES - 1));
            cnt = PAGE_CNT_W'($urandom_range(8, 1));
        end else if (pick < 94) begin
            op = t_op'($urandom_range(3));
            page = PAGE_NUM_W'($urandom_range(TOTAL_PAGES - 1));
            cnt = '0;
        end else if (pick < 97) begin
            // hopeless huge request
            op = OP_ALLOC_HUGE;
            cnt = PAGE_CNT_W'($urandom_range(2 ** PAGE_CNT_W - 1, DIR_ENTRIES + 1));
        end else begin
            // occasionally drop a table entry out from under its marks
            op = OP_FREE_HUGE;
            page = PAGE_NUM_W'($urandom_range(4 * PAGES_PER_ENTRY - 1));
            cnt = PAGE_CNT_W'(1);
        end
        send_item(op, page, cnt, 1'b0, '0, 1'b0);
    endtask

    // Directed rows. Typed expectations only where obvious.
    stim_row_t dir_rows [NUM_ROWS] = '{
        // zero count does nothing
        '{OP_ALLOC_SMALL, 18'd0,      19'd0,      1'b1, 18'd0,    1'b0},
        // counts far beyond the window fail
        '{OP_ALLOC_HUGE,  18'd0,      19'h7FFFF,  1'b1, 18'd0,    1'b1},
        '{OP_ALLOC_SMALL, 18'd0,      19'h7FFFF,  1'b1, 18'd0,    1'b1},
        // first table at entry 0
        '{OP_ALLOC_SMALL, 18'd0,      19'd1,      1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd511,    1'b1, 18'd1,    1'b0},
        // table 0 full, next table from entry 1
        '{OP_ALLOC_SMALL, 18'd0,      19'd1,      1'b1, 18'd512,  1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd1,      1'b0, 18'd0,    1'b0},
        '{OP_FREE_SMALL,  18'd0,      19'd1,      1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd1,      1'b0, 18'd0,    1'b0},
        // run starting right at a table boundary
        '{OP_FREE_SMALL,  18'd512,    19'd2,      1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd2,      1'b0, 18'd0,    1'b0},
        '{OP_ALLOC_HUGE,  18'd0,      19'd1,      1'b1, 18'd1024, 1'b0},
        '{OP_ALLOC_HUGE,  18'd0,      19'd512,    1'b1, 18'd0,    1'b1},
        // freeing a table entry keeps its marks
        '{OP_FREE_HUGE,   18'd600,    19'd1,      1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd3,      1'b0, 18'd0,    1'b0},
        // small free over a huge entry
        '{OP_FREE_SMALL,  18'd1024,   19'd3,      1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_HUGE,  18'd0,      19'd2,      1'b0, 18'd0,    1'b0},
        // frees clipped at the window end
        '{OP_FREE_SMALL,  18'h3FFFF,  19'h7FFFF,  1'b1, 18'd0,    1'b0},
        '{OP_FREE_HUGE,   18'h3FFFF,  19'h7FFFF,  1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_HUGE,  18'd0,      19'd2,      1'b0, 18'd0,    1'b0},
        // clear the whole directory, old marks survive
        '{OP_FREE_HUGE,   18'd0,      19'h7FFFF,  1'b1, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd5,      1'b0, 18'd0,    1'b0},
        '{OP_ALLOC_SMALL, 18'd0,      19'd600,    1'b0, 18'd0,    1'b0},
        '{OP_FREE_HUGE,   18'd0,      19'd0,      1'b1, 18'd0,    1'b0}
    };

    initial begin
        int unsigned waited;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.operation = OP_ALLOC_SMALL;
        req_if.page_number = '0;
        req_if.page_count = '0;
        rsp_if.ready = 1'b0;
        row_fixed = 1'b0;
        row_start = '0;
        row_status = 1'b0;
        for (int i = 0; i < DIR_ENTRIES; i++) dir_kind[i] = KIND_FREE;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].page, dir_rows[i].count,
                      dir_rows[i].fixed, dir_rows[i].start_page, dir_rows[i].status);
        go_quiet();
        small_runs.delete();
        huge_runs.delete();

        // random part over four idling profiles
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 60; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 60; end
                default: begin tx_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // back-pressure: receiver holds off while the sender keeps going
                if (ph == 0 && n == 5) holdoff_go = 1;
                send_random();
            end
            // sender pauses until everything has come back
            go_quiet();
        end

        tx_idle_pct = 0;
        rx_stall_pct = 0;
        req_if.valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < HANG_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d directed, rest random over four idling profiles),",
                 items_in, NUM_ROWS);
        $display("%0d responses checked, %0d out-of-memory answers.", items_out, oom_seen);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d responses missing", fail_count,
                     pending_results.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
